// ===== design/tlpm_pkg.sv =====
// tlpm_pkg: shared constants, codes and controller/datapath interface types
// for the two-level page map unit. No dependencies.

package tlpm_pkg;

  localparam int LEAF_TABLES_DEF = 16;

  localparam int IDX_W     = 10;
  localparam int DIR_DEPTH = 1 << IDX_W;
  localparam int PPN_W     = 20;
  localparam int OFF_W     = 12;
  localparam int LEAF_W    = 26;
  localparam int LEAF_VALID_BIT = 25;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_INSERT    = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_MISS     = 2'd1;
  localparam logic [1:0] STS_MAPPED   = 2'd2;
  localparam logic [1:0] STS_NO_TABLE = 2'd3;

  typedef struct packed {
    logic clear;
    logic accept;
    logic dir_eval;
    logic leaf_eval;
  } tlpm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dir_hit;
    logic out_busy;
  } tlpm_stat_t;

endpackage

// ===== design/two_level_page_map_unit.sv =====
// two_level_page_map_unit: top level of the two-level virtual-to-physical page map.
// Joins tlpm_ctrl and tlpm_dp; uses tlpm_pkg.
//
//   channel  | dir | handshake           | payload
//   in_      | in  | in_tvalid/in_tready | tdata: virt_addr, phys_addr, r,w,x,u,g; tuser: kind
//   out_     | out | out_tvalid/out_tready | tdata: status, phys_out
//
// A request steps through accept, directory read and leaf read; the leaf read
// is skipped when the directory slot is empty. The two dependent reads of the
// directory and leaf memories set this sequence. A result waits in the output
// register; the next word is taken once that register is free or being emptied.
// After reset a clearing pass over all LEAF_TABLES*1024 leaf entries sweeps
// both memories with in_tready low.

module two_level_page_map_unit #(
  parameter int LEAF_TABLES = tlpm_pkg::LEAF_TABLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // virt_addr[31:0], phys_addr[63:32], readable[64], writable[65],
  // executable[66], user_ok[67], global_map[68], zero[71:69]
  input  logic [tlpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], phys_out[33:2], zero[39:34]
  output logic [tlpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tlpm_pkg::*;

  tlpm_cmd_t  cmd;
  tlpm_stat_t stat;

  tlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlpm_dp #(
    .LEAF_TABLES (LEAF_TABLES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/tlpm_ram.sv =====
// tlpm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tlpm_ctrl.sv =====
// tlpm_ctrl: request sequencer for the page map unit (clear sweep, accept,
// directory step, leaf step). Depends on tlpm_pkg.

module tlpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tlpm_pkg::tlpm_stat_t stat,
  output tlpm_pkg::tlpm_cmd_t  cmd
);
  import tlpm_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DIR   = 2'd2;
  localparam logic [1:0] S_LEAF  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // a word is only taken when its result will find the output free
        in_tready = !stat.out_busy;
        if (in_tvalid && !stat.out_busy) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIR;
        end
      end
      S_DIR: begin
        cmd.dir_eval = 1'b1;
        state_nxt    = stat.dir_hit ? S_LEAF : S_IDLE;
      end
      S_LEAF: begin
        cmd.leaf_eval = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/tlpm_dp.sv =====
// tlpm_dp: datapath of the page map unit: request registers, directory and
// leaf memories, table pool counter, clear sweep and result register.
// Depends on tlpm_pkg and tlpm_ram.

module tlpm_dp #(
  parameter int LEAF_TABLES = tlpm_pkg::LEAF_TABLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlpm_pkg::tlpm_cmd_t                cmd,
  output tlpm_pkg::tlpm_stat_t               stat,
  input  logic [tlpm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlpm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tlpm_pkg::*;

  localparam int TIDX_W     = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
  localparam int UCNT_W     = $clog2(LEAF_TABLES + 1);
  localparam int LEAF_DEPTH = LEAF_TABLES * DIR_DEPTH;
  localparam int LADDR_W    = $clog2(LEAF_DEPTH);
  localparam int DIR_W      = TIDX_W + 1;

  // request registers
  logic              kind_r;
  logic [31:0]       va_r;
  logic [PPN_W-1:0]  ppn_r;
  logic [4:0]        attr_r;   // g,u,x,w,r from high to low

  logic [UCNT_W-1:0]  tables_used_r, tables_used_nxt;
  logic [LADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LADDR_W-1:0] leaf_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [31:0]       out_phys_r;

  logic              dir_we, leaf_we;
  logic [IDX_W-1:0]  dir_waddr;
  logic [DIR_W-1:0]  dir_wdata, dir_rdata;
  logic [LADDR_W-1:0] leaf_waddr, leaf_raddr;
  logic [LEAF_W-1:0] leaf_wdata, leaf_rdata, new_entry;

  logic              dir_valid, pool_full, alloc, leaf_valid, leaf_ins;
  logic [TIDX_W-1:0] dir_tidx, new_tidx;
  logic [TIDX_W+IDX_W-1:0] hit_full, alloc_full;
  logic [PPN_W-1:0]  leaf_ppn;
  logic              out_load;
  logic [1:0]        res_status;
  logic [31:0]       res_phys;

  assign dir_valid  = dir_rdata[DIR_W-1];
  assign dir_tidx   = dir_rdata[TIDX_W-1:0];
  assign pool_full  = (tables_used_r == UCNT_W'(LEAF_TABLES));
  assign new_tidx   = TIDX_W'(tables_used_r);
  assign alloc      = cmd.dir_eval && (kind_r == KIND_INSERT) && !dir_valid && !pool_full;

  assign hit_full   = {dir_tidx, va_r[21:12]};
  assign alloc_full = {new_tidx, va_r[21:12]};
  assign leaf_raddr = hit_full[LADDR_W-1:0];

  assign leaf_valid = leaf_rdata[LEAF_VALID_BIT];
  assign leaf_ppn   = leaf_rdata[PPN_W-1:0];
  assign leaf_ins   = cmd.leaf_eval && (kind_r == KIND_INSERT) && !leaf_valid;
  assign new_entry  = {1'b1, attr_r, ppn_r};

  // a freshly bound table is known clear, so the entry is written at once
  assign dir_we     = cmd.clear || alloc;
  assign dir_waddr  = cmd.clear ? clr_cnt_r[IDX_W-1:0] : va_r[31:22];
  assign dir_wdata  = cmd.clear ? '0 : {1'b1, new_tidx};

  assign leaf_we    = cmd.clear || alloc || leaf_ins;
  assign leaf_wdata = cmd.clear ? '0 : new_entry;

  always_comb begin
    if (cmd.clear) begin
      leaf_waddr = clr_cnt_r;
    end else if (cmd.dir_eval) begin
      leaf_waddr = alloc_full[LADDR_W-1:0];
    end else begin
      leaf_waddr = leaf_addr_r;
    end
  end

  always_comb begin
    res_status = STS_OK;
    res_phys   = '0;
    if (cmd.dir_eval) begin
      if (kind_r == KIND_TRANSLATE) begin
        res_status = STS_MISS;
      end else if (pool_full) begin
        res_status = STS_NO_TABLE;
      end
    end else if (kind_r == KIND_INSERT) begin
      if (leaf_valid) begin
        res_status = STS_MAPPED;
      end
    end else if (leaf_valid && (leaf_ppn != '0)) begin
      res_phys = {leaf_ppn, va_r[OFF_W-1:0]};
    end else begin
      res_status = STS_MISS;
    end
  end

  assign out_load      = (cmd.dir_eval && !dir_valid) || cmd.leaf_eval;
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);
  assign tables_used_nxt = alloc ? tables_used_r + 1'b1 : tables_used_r;
  assign clr_cnt_nxt   = cmd.clear ? clr_cnt_r + 1'b1 : clr_cnt_r;

  assign stat.clr_last = (clr_cnt_r == LADDR_W'(LEAF_DEPTH - 1));
  assign stat.dir_hit  = dir_valid;
  assign stat.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_phys_r, out_status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tables_used_r <= '0;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      tables_used_r <= tables_used_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser;
      va_r   <= in_tdata[31:0];
      ppn_r  <= in_tdata[63:44];
      attr_r <= {in_tdata[68], in_tdata[67], in_tdata[66], in_tdata[65], in_tdata[64]};
    end
    if (cmd.dir_eval) begin
      leaf_addr_r <= leaf_raddr;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_phys_r   <= res_phys;
    end
  end

  tlpm_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (in_tdata[31:22]),
    .rdata (dir_rdata)
  );

  tlpm_ram #(
    .WIDTH (LEAF_W),
    .DEPTH (LEAF_DEPTH)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

endmodule

// ===== design/tlpm_checker.sv =====
// tlpm_checker: port-level assertions for two_level_page_map_unit, bound to it.
// Depends on tlpm_pkg.

module tlpm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tlpm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // no word is taken while a result is stuck
  a_no_take_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(out_tvalid && !out_tready))
    else $error("input taken while output stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  // only a successful translate carries an address
  a_phys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != STS_OK) |-> (out_tdata[33:2] == 32'd0))
    else $error("nonzero address with error status");

endmodule

bind two_level_page_map_unit tlpm_checker u_tlpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
